@@ design/sbcb_pkg.sv @@
// Shared types, codes and constants for the shared burst credit block.
`default_nettype none
package sbcb_pkg;

  localparam int OWNERS = 16;
  localparam int ByteW  = 40;
  localparam int OwnerW = 4;
  localparam int CfgIdxW = 3;
  localparam int WakeW  = 16;

  typedef enum logic [2:0] {
    OP_ENQUEUE = 3'd0,
    OP_FREE    = 3'd1,
    OP_CHECK   = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_CANCEL  = 3'd4
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE     = 3'd0,
    CFG_CONTINUE = 3'd1,
    CFG_BURST    = 3'd2,
    CFG_POOL     = 3'd3,
    CFG_HEADROOM = 3'd4
  } cfg_idx_e;

  localparam logic [ByteW-1:0] BaseReset     = 40'd33554432;
  localparam logic [ByteW-1:0] ContinueReset = 40'd29360128;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_QUPD,
    S_LIMIT,
    S_NEED,
    S_CREDIT,
    S_POOL,
    S_FIT,
    S_COMMIT
  } state_e;

  typedef struct packed {
    logic [ByteW-1:0] base_limit;
    logic [ByteW-1:0] continue_limit;
    logic [ByteW-1:0] burst_limit;
    logic [ByteW-1:0] global_burst_pool;
    logic [ByteW-1:0] min_headroom;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic read;
    logic qupd;
    logic limit;
    logic need;
    logic credit;
    logic pool;
    logic fit;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic short_path;
  } status_t;

endpackage
`default_nettype wire

@@ design/sbcb_cfg.sv @@
// Configuration register file of the shared burst credit block.
`default_nettype none
module sbcb_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sbcb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [sbcb_pkg::ByteW-1:0]    cfg_data_i,
  output sbcb_pkg::cfg_t                     cfg_o
);
  import sbcb_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BASE:     cfg_d.base_limit        = cfg_data_i;
        CFG_CONTINUE: cfg_d.continue_limit    = cfg_data_i;
        CFG_BURST:    cfg_d.burst_limit       = cfg_data_i;
        CFG_POOL:     cfg_d.global_burst_pool = cfg_data_i;
        CFG_HEADROOM: cfg_d.min_headroom      = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_limit        <= BaseReset;
      cfg_q.continue_limit    <= ContinueReset;
      cfg_q.burst_limit       <= '0;
      cfg_q.global_burst_pool <= '0;
      cfg_q.min_headroom      <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ design/sbcb_ctrl.sv @@
// Sequencer that steps one request through the credit datapath.
`default_nettype none
module sbcb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire sbcb_pkg::status_t status_i,
  output sbcb_pkg::cmd_t     cmd_o
);
  import sbcb_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // the result register can take a new request once the old one leaves
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_READ;
      S_READ:   state_d = S_QUPD;
      S_QUPD:   state_d = status_i.short_path ? S_COMMIT : S_LIMIT;
      S_LIMIT:  state_d = S_NEED;
      S_NEED:   state_d = S_CREDIT;
      S_CREDIT: state_d = S_POOL;
      S_POOL:   state_d = S_FIT;
      S_FIT:    state_d = S_COMMIT;
      S_COMMIT: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = (state_q == S_IDLE) && in_valid_i;
    cmd_o.read   = (state_q == S_READ);
    cmd_o.qupd   = (state_q == S_QUPD);
    cmd_o.limit  = (state_q == S_LIMIT);
    cmd_o.need   = (state_q == S_NEED);
    cmd_o.credit = (state_q == S_CREDIT);
    cmd_o.pool   = (state_q == S_POOL);
    cmd_o.fit    = (state_q == S_FIT);
    cmd_o.commit = (state_q == S_COMMIT) && out_free;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.commit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

@@ design/sbcb_dpath.sv @@
// Datapath: per-owner byte and loan tables, pool total, waiter bits, result.
`default_nettype none
module sbcb_dpath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire sbcb_pkg::cfg_t              cfg_i,
  input  wire sbcb_pkg::cmd_t              cmd_i,
  output sbcb_pkg::status_t                status_o,
  input  wire logic [2:0]                  operation_i,
  input  wire logic [sbcb_pkg::OwnerW-1:0] owner_i,
  input  wire logic [sbcb_pkg::ByteW-1:0]  byte_count_i,
  input  wire logic [sbcb_pkg::ByteW-1:0]  headroom_bytes_i,
  input  wire logic                        headroom_valid_i,
  output logic                             blocked_o,
  output logic [sbcb_pkg::WakeW-1:0]       wake_mask_o,
  output logic [sbcb_pkg::ByteW-1:0]       owner_loan_o,
  output logic                             underflow_o
);
  import sbcb_pkg::*;

  // request fields
  op_e              op_q;
  logic [OwnerW-1:0] who_q;
  logic [ByteW-1:0] bytes_q, room_q;
  logic             room_ok_q;

  // per-step working registers
  logic [ByteW-1:0] q_q, cur_q, qn_q, mq_q, need_q, down_q, extra_q;
  logic [ByteW-1:0] gmx_q, pool_dn_q, pool_add_q;
  logic             on_q, hr_fail_q, under_q, ge_base_q, at_top_q, le_cont_q;
  logic             need_le_cur_q, need_lt_cur_q, ext_ovf_q, fit_fail_q;

  // block state
  logic [ByteW-1:0]  queued_q [OWNERS];
  logic [ByteW-1:0]  queued_d [OWNERS];
  logic [ByteW-1:0]  credit_q [OWNERS];
  logic [ByteW-1:0]  credit_d [OWNERS];
  logic [ByteW-1:0]  pool_used_q, pool_used_d;
  logic [OWNERS-1:0] legacy_q, legacy_d, poolw_q, poolw_d;

  // result
  logic             blocked_q, blocked_d, under_out_q;
  logic [OWNERS-1:0] wake_q, wake_d;
  logic [ByteW-1:0] loan_q, loan_d;

  // stage logic
  logic [ByteW:0]   sum, qdiff, cdiff, ndiff, gdiff, pdiff;
  logic [ByteW-1:0] qn_d, sub_amt;
  logic             under_d, ge_burst;
  logic [OWNERS-1:0] bit_sel;

  assign status_o.short_path = !(op_q == OP_FREE || op_q == OP_CHECK || op_q == OP_REMOVE);

  // new queued bytes: saturating add or clamped subtract
  always_comb begin
    sum   = {1'b0, q_q} + {1'b0, bytes_q};
    qdiff = {1'b0, q_q} - {1'b0, bytes_q};
    qn_d    = q_q;
    under_d = 1'b0;
    if (op_q == OP_ENQUEUE) begin
      qn_d = sum[ByteW] ? {ByteW{1'b1}} : sum[ByteW-1:0];
    end else if (op_q == OP_FREE) begin
      under_d = qdiff[ByteW];
      qn_d    = qdiff[ByteW] ? '0 : qdiff[ByteW-1:0];
    end
  end

  assign ge_burst = (qn_q >= cfg_i.burst_limit);
  assign cdiff    = {1'b0, cur_q} - {1'b0, need_q};
  assign ndiff    = {1'b0, need_q} - {1'b0, cur_q};
  assign gdiff    = {1'b0, cfg_i.global_burst_pool} - {1'b0, extra_q};
  assign sub_amt  = (op_q == OP_REMOVE) ? cur_q : down_q;
  assign pdiff    = {1'b0, pool_used_q} - {1'b0, sub_amt};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q      <= op_e'(operation_i);
      who_q     <= owner_i;
      bytes_q   <= byte_count_i;
      room_q    <= headroom_bytes_i;
      room_ok_q <= headroom_valid_i;
    end
    if (cmd_i.read) begin
      q_q       <= queued_q[who_q];
      cur_q     <= credit_q[who_q];
      on_q      <= (cfg_i.burst_limit > cfg_i.base_limit) &&
                   (cfg_i.global_burst_pool != '0);
      hr_fail_q <= (cfg_i.min_headroom != '0) &&
                   (!room_ok_q || room_q <= cfg_i.min_headroom);
    end
    if (cmd_i.qupd) begin
      qn_q    <= qn_d;
      under_q <= under_d;
    end
    if (cmd_i.limit) begin
      ge_base_q <= (qn_q >= cfg_i.base_limit);
      at_top_q  <= ge_burst;
      le_cont_q <= (qn_q <= cfg_i.continue_limit);
      mq_q      <= ge_burst ? cfg_i.burst_limit : qn_q;
    end
    if (cmd_i.need) begin
      need_q <= ge_base_q ? mq_q - cfg_i.base_limit : '0;
    end
    if (cmd_i.credit) begin
      need_le_cur_q <= !cdiff[ByteW];
      down_q        <= cdiff[ByteW-1:0];
      extra_q       <= ndiff[ByteW-1:0];
    end
    if (cmd_i.pool) begin
      ext_ovf_q     <= gdiff[ByteW];
      gmx_q         <= gdiff[ByteW-1:0];
      pool_dn_q     <= pdiff[ByteW] ? '0 : pdiff[ByteW-1:0];
      need_lt_cur_q <= need_le_cur_q && (down_q != '0);
    end
    if (cmd_i.fit) begin
      fit_fail_q <= ext_ovf_q || (pool_used_q > gmx_q);
      pool_add_q <= pool_used_q + extra_q;
    end
    if (cmd_i.commit) begin
      blocked_q   <= blocked_d;
      wake_q      <= wake_d;
      loan_q      <= loan_d;
      under_out_q <= (op_q == OP_FREE) && under_q;
    end
  end

  always_comb begin
    bit_sel     = {{(OWNERS-1){1'b0}}, 1'b1} << who_q;
    queued_d    = queued_q;
    credit_d    = credit_q;
    pool_used_d = pool_used_q;
    legacy_d    = legacy_q;
    poolw_d     = poolw_q;
    blocked_d   = 1'b0;
    wake_d      = '0;
    case (op_q)
      OP_ENQUEUE: queued_d[who_q] = qn_q;
      OP_FREE: begin
        queued_d[who_q] = qn_q;
        if (on_q) begin
          // shrink the loan to the bytes still above the base limit
          if (need_lt_cur_q) begin
            pool_used_d     = pool_dn_q;
            credit_d[who_q] = need_q;
          end
          wake_d  = poolw_q;
          poolw_d = '0;
        end
        if (le_cont_q && legacy_q[who_q]) begin
          wake_d          = wake_d | bit_sel;
          legacy_d[who_q] = 1'b0;
        end
      end
      OP_CHECK: begin
        if (ge_base_q) begin
          if (!on_q || hr_fail_q) begin
            blocked_d = 1'b1;
          end else if (need_le_cur_q) begin
            pool_used_d     = pool_dn_q;
            credit_d[who_q] = need_q;
            blocked_d       = at_top_q;
          end else if (fit_fail_q) begin
            blocked_d = 1'b1;
          end else begin
            pool_used_d     = pool_add_q;
            credit_d[who_q] = need_q;
            blocked_d       = at_top_q;
          end
          if (blocked_d) begin
            if (on_q) poolw_d = poolw_q | bit_sel;
            else      legacy_d = legacy_q | bit_sel;
          end
        end
      end
      OP_REMOVE: begin
        pool_used_d     = pool_dn_q;
        credit_d[who_q] = '0;
        if (cur_q != '0) begin
          wake_d  = poolw_q;
          poolw_d = '0;
        end else if (poolw_q[who_q]) begin
          wake_d         = bit_sel;
          poolw_d[who_q] = 1'b0;
        end
      end
      OP_CANCEL: begin
        wake_d          = (legacy_q | poolw_q) & bit_sel;
        legacy_d[who_q] = 1'b0;
        poolw_d[who_q]  = 1'b0;
      end
      default: ;
    endcase
    loan_d = credit_d[who_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_q    <= '{default: '0};
      credit_q    <= '{default: '0};
      pool_used_q <= '0;
      legacy_q    <= '0;
      poolw_q     <= '0;
    end else if (cmd_i.commit) begin
      queued_q    <= queued_d;
      credit_q    <= credit_d;
      pool_used_q <= pool_used_d;
      legacy_q    <= legacy_d;
      poolw_q     <= poolw_d;
    end
  end

  assign blocked_o    = blocked_q;
  assign wake_mask_o  = WakeW'(wake_q);
  assign owner_loan_o = loan_q;
  assign underflow_o  = under_out_q;

endmodule
`default_nettype wire

@@ design/shared_burst_credit_backpressure.sv @@
// Sequence: after acceptance, enqueue, cancel and unknown codes step through READ, QUPD and
// COMMIT; free, check and remove also pass LIMIT, NEED, CREDIT, POOL and FIT (a chain of
// 40-bit add/compare steps on one entry). The result register frees the input side so a
// new request is taken while the previous result waits for its receiver.
// Reset: asynchronous, clears all queued bytes, loans, pool usage and waiter bits and
// loads the register defaults; no clearing pass, a request is accepted right after reset.
`default_nettype none
module shared_burst_credit_backpressure (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sbcb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [sbcb_pkg::ByteW-1:0]    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [2:0]                    operation_i,
  input  wire logic [sbcb_pkg::OwnerW-1:0]   owner_i,
  input  wire logic [sbcb_pkg::ByteW-1:0]    byte_count_i,
  input  wire logic [sbcb_pkg::ByteW-1:0]    headroom_bytes_i,
  input  wire logic                          headroom_valid_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               blocked_o,
  output logic [sbcb_pkg::WakeW-1:0]         wake_mask_o,
  output logic [sbcb_pkg::ByteW-1:0]         owner_loan_o,
  output logic                               underflow_o
);
  import sbcb_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  sbcb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sbcb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sbcb_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .status_o         (status),
    .operation_i      (operation_i),
    .owner_i          (owner_i),
    .byte_count_i     (byte_count_i),
    .headroom_bytes_i (headroom_bytes_i),
    .headroom_valid_i (headroom_valid_i),
    .blocked_o        (blocked_o),
    .wake_mask_o      (wake_mask_o),
    .owner_loan_o     (owner_loan_o),
    .underflow_o      (underflow_o)
  );

endmodule
`default_nettype wire
